/* src/cst_pkg.sv */
`default_nettype none

package cst_pkg;

  // configuration register widths, indexes and reset values
  localparam int TENSION_W   = 9;
  localparam int GRAIN_W     = 4;
  localparam int USTEP_W     = 16;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_TENSION = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_GRAIN   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_U_STEP  = 2'd2;

  localparam logic [TENSION_W-1:0] TENSION_RESET = 9'd128;
  localparam logic [GRAIN_W-1:0]   GRAIN_RESET   = 4'd4;
  localparam logic [USTEP_W-1:0]   USTEP_RESET   = 16'd13107;

  // horner evaluation: accumulator split into 32-bit limbs, result scaled by 2^56
  localparam int LIMB_W      = 32;
  localparam int ROUND_SHIFT = 56;

  typedef logic [1:0] emit_sel_t;
  localparam emit_sel_t EMIT_POINT  = 2'd0;
  localparam emit_sel_t EMIT_WINDOW = 2'd1;
  localparam emit_sel_t EMIT_ITEM   = 2'd2;

  typedef logic [1:0] mul_stage_t;
  localparam mul_stage_t STAGE_C1 = 2'd0;
  localparam mul_stage_t STAGE_C2 = 2'd1;
  localparam mul_stage_t STAGE_C3 = 2'd2;

  typedef struct packed {
    logic       take;
    logic       first_load;
    logic       store;
    logic       shift;
    logic       clear;
    logic       coef;
    logic       load;
    logic       mul;
    logic       mul_hi;
    mul_stage_t mul_stage;
    logic       emit;
    emit_sel_t  emit_sel;
    logic       mark_last;
    logic       mark_end;
  } cmd_t;

  typedef struct packed {
    logic first;
    logic last;
    logic full;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

/* src/cst_in_if.sv */
`default_nettype none

interface cst_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] in_x;
  logic signed [COORD_BITS-1:0] in_y;
  logic                         first_point;
  logic                         last_point;

  modport source (output valid, in_x, in_y, first_point, last_point, input ready);
  modport sink   (input valid, in_x, in_y, first_point, last_point, output ready);
endinterface

`default_nettype wire

/* src/cst_out_if.sv */
`default_nettype none

interface cst_out_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] out_x;
  logic signed [COORD_BITS-1:0] out_y;
  logic                         is_knot;
  logic                         last_of_run;
  logic                         end_of_curve;

  modport source (output valid, out_x, out_y, is_knot, last_of_run, end_of_curve,
                  input ready);
  modport sink   (input valid, out_x, out_y, is_knot, last_of_run, end_of_curve,
                  output ready);
endinterface

`default_nettype wire

/* src/cardinal_spline_tessellator_core.sv */
`default_nettype none

// Streaming cardinal spline tessellator. Control points arrive one per beat on
// the points channel, flagged first_point / last_point; the first point is
// doubled as a virtual start knot and the last as a virtual end knot. Every
// completed four-knot window sends grain interpolated points (u = j*u_step,
// saturated to 65535) followed by its inner end knot on the curve channel.
// One item is worked on at a time. An item that only fills the window passes
// through S_IDLE, S_BEGIN and S_PUSH. With a full window each interpolated
// point (grain, clamped to MAX_GRAIN) needs a load step, three horner steps,
// each over two 32-bit limbs of the accumulator on the single 33x17 multiplier
// of each axis, and an output step. A first point adds two output beats, a
// last point a second window push and the end knot beat. The curve channel
// has an output register, so the next point is taken while the last result
// still waits; curve channel backpressure stalls the sequencer. Configuration
// (tension, grain, u_step) is to be written through cfg_wr_en / cfg_index /
// cfg_wdata only while the block is idle; the block does not enforce this.

module cardinal_spline_tessellator_core #(
  parameter int COORD_BITS = 16,
  parameter int MAX_GRAIN  = 15
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  cst_in_if.sink                               points,
  cst_out_if.source                            curve,
  input  wire logic                            cfg_wr_en,
  input  wire logic [cst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [cst_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // configuration registers
  logic [cst_pkg::TENSION_W-1:0] tension;
  logic [cst_pkg::GRAIN_W-1:0]   grain;
  logic [cst_pkg::USTEP_W-1:0]   u_step;

  // command and status between sequencer and datapath
  cst_pkg::cmd_t  cmd;
  cst_pkg::stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      tension <= cst_pkg::TENSION_RESET;
      grain   <= cst_pkg::GRAIN_RESET;
      u_step  <= cst_pkg::USTEP_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cst_pkg::CFG_TENSION: tension <= cfg_wdata[cst_pkg::TENSION_W-1:0];
        cst_pkg::CFG_GRAIN:   grain   <= cfg_wdata[cst_pkg::GRAIN_W-1:0];
        cst_pkg::CFG_U_STEP:  u_step  <= cfg_wdata[cst_pkg::USTEP_W-1:0];
        default: ;   // unmapped index is ignored
      endcase
    end
  end

  // sequencer: item intake, window pushes, point and knot beats
  cst_ctrl #(.MAX_GRAIN(MAX_GRAIN)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (points.valid),
    .in_ready (points.ready),
    .grain    (grain),
    .stat     (stat),
    .cmd      (cmd)
  );

  // knot window, coefficient set-up, horner evaluation, output register
  cst_datapath #(.COORD_BITS(COORD_BITS)) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .tension      (tension),
    .u_step       (u_step),
    .in_x         (points.in_x),
    .in_y         (points.in_y),
    .first_point  (points.first_point),
    .last_point   (points.last_point),
    .out_valid    (curve.valid),
    .out_ready    (curve.ready),
    .out_x        (curve.out_x),
    .out_y        (curve.out_y),
    .is_knot      (curve.is_knot),
    .last_of_run  (curve.last_of_run),
    .end_of_curve (curve.end_of_curve)
  );

endmodule

`default_nettype wire

/* src/cst_axis.sv */
`default_nettype none

module cst_axis #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                                clk,
  input  wire cst_pkg::cmd_t                       cmd,
  input  wire logic [cst_pkg::TENSION_W-1:0]       tension,
  input  wire logic [cst_pkg::USTEP_W-1:0]         u,
  input  wire logic [1:0]                          held,
  input  wire logic signed [COORD_BITS-1:0]        coord_in,
  output logic signed [COORD_BITS-1:0]             emit_val
);

  localparam int DW    = COORD_BITS + 3;
  localparam int CW    = COORD_BITS + 14;
  localparam int A2W   = CW + 34;
  localparam int ACC_W = CW + 52;
  localparam int HI_W  = A2W - cst_pkg::LIMB_W;
  localparam int OPW   = (HI_W > cst_pkg::LIMB_W) ? HI_W : cst_pkg::LIMB_W + 1;
  localparam int PW    = OPW + cst_pkg::USTEP_W + 1;
  localparam int QW    = ACC_W - cst_pkg::ROUND_SHIFT;
  localparam int TW    = cst_pkg::TENSION_W + 1;

  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (cst_pkg::ROUND_SHIFT - 1);
  localparam logic signed [QW-1:0] Q_MAX = QW'((longint'(1) <<< (COORD_BITS - 1)) - 1);
  localparam logic signed [QW-1:0] Q_MIN = QW'(-(longint'(1) <<< (COORD_BITS - 1)));
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};

  logic signed [COORD_BITS-1:0] win [3];
  logic signed [COORD_BITS-1:0] pt;
  logic signed [CW-1:0]         c0, c1, c2;
  logic signed [ACC_W-1:0]      acc, tmp;

  logic signed [DW-1:0]         a_e, b_e, c_e, d_e, s0, s1, s2, bc;
  logic signed [TW-1:0]         ts;
  logic signed [CW-1:0]         c0_next, c1_next, c2_next, c3;
  logic signed [OPW-1:0]        opnd;
  logic signed [PW-1:0]         prod;
  logic signed [ACC_W-1:0]      prod_e, cadd, rounded;
  logic signed [QW-1:0]         q;
  logic signed [COORD_BITS-1:0] point_val;

  // coefficients of the cubic, matrix scaled by 256
  always_comb begin
    a_e = DW'(win[0]);
    b_e = DW'(win[1]);
    c_e = DW'(win[2]);
    d_e = DW'(pt);
    s0  = d_e - a_e - b_e + c_e;
    s1  = (a_e <<< 1) + b_e - (c_e <<< 1) - d_e;
    s2  = c_e - a_e;
    bc  = b_e - c_e;
    ts  = signed'({1'b0, tension});
    c0_next = CW'(ts) * CW'(s0) + (CW'(bc) <<< 9);
    c1_next = CW'(ts) * CW'(s1) - (CW'(bc) <<< 9) - (CW'(bc) <<< 8);
    c2_next = CW'(ts) * CW'(s2);
    c3      = CW'(win[1]) <<< 8;
  end

  // one limb of the accumulator times u per beat
  always_comb begin
    if (cmd.mul_hi) begin
      opnd = OPW'(signed'(acc[A2W-1:cst_pkg::LIMB_W]));
    end else begin
      opnd = OPW'(signed'({1'b0, acc[cst_pkg::LIMB_W-1:0]}));
    end
    prod   = PW'(opnd) * PW'(signed'({1'b0, u}));
    prod_e = ACC_W'(prod);
    unique case (cmd.mul_stage)
      cst_pkg::STAGE_C1: cadd = ACC_W'(c1) <<< 16;
      cst_pkg::STAGE_C2: cadd = ACC_W'(c2) <<< 32;
      cst_pkg::STAGE_C3: cadd = ACC_W'(c3) <<< 48;
      default:           cadd = '0;
    endcase
  end

  // round half up, then saturate
  always_comb begin
    rounded = acc + HALF;
    q       = signed'(rounded[ACC_W-1:cst_pkg::ROUND_SHIFT]);
    if (q > Q_MAX) begin
      point_val = C_MAX;
    end else if (q < Q_MIN) begin
      point_val = C_MIN;
    end else begin
      point_val = COORD_BITS'(q);
    end
    unique case (cmd.emit_sel)
      cst_pkg::EMIT_POINT:  emit_val = point_val;
      cst_pkg::EMIT_WINDOW: emit_val = win[2];
      cst_pkg::EMIT_ITEM:   emit_val = pt;
      default:              emit_val = pt;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pt <= coord_in;
    end
    if (cmd.first_load) begin
      win[0] <= pt;
      win[1] <= pt;
      win[2] <= '0;
    end else if (cmd.store) begin
      unique case (held)
        2'd0:    win[0] <= pt;
        2'd1:    win[1] <= pt;
        2'd2:    win[2] <= pt;
        default: ;
      endcase
    end else if (cmd.shift) begin
      win[0] <= win[1];
      win[1] <= win[2];
      win[2] <= pt;
    end
    if (cmd.coef) begin
      c0 <= c0_next;
      c1 <= c1_next;
      c2 <= c2_next;
    end
    if (cmd.load) begin
      acc <= ACC_W'(c0);
    end else if (cmd.mul) begin
      if (cmd.mul_hi) begin
        acc <= tmp + (prod_e <<< cst_pkg::LIMB_W);
      end else begin
        tmp <= prod_e + cadd;
      end
    end
  end

endmodule

`default_nettype wire

/* src/cst_datapath.sv */
`default_nettype none

module cst_datapath #(
  parameter int COORD_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire cst_pkg::cmd_t                 cmd,
  output cst_pkg::stat_t                     stat,
  input  wire logic [cst_pkg::TENSION_W-1:0] tension,
  input  wire logic [cst_pkg::USTEP_W-1:0]   u_step,
  input  wire logic signed [COORD_BITS-1:0]  in_x,
  input  wire logic signed [COORD_BITS-1:0]  in_y,
  input  wire logic                          first_point,
  input  wire logic                          last_point,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [COORD_BITS-1:0]       out_x,
  output logic signed [COORD_BITS-1:0]       out_y,
  output logic                               is_knot,
  output logic                               last_of_run,
  output logic                               end_of_curve
);

  localparam logic [1:0] HELD_START = 2'd2;
  localparam logic [1:0] HELD_FULL  = 2'd3;

  logic [1:0]                   held;
  logic [cst_pkg::USTEP_W-1:0]  u;
  logic [cst_pkg::USTEP_W:0]    u_sum;
  logic                         item_first, item_last;
  logic signed [COORD_BITS-1:0] x_val, y_val;

  cst_axis #(.COORD_BITS(COORD_BITS)) u_axis_x (
    .clk      (clk),
    .cmd      (cmd),
    .tension  (tension),
    .u        (u),
    .held     (held),
    .coord_in (in_x),
    .emit_val (x_val)
  );

  cst_axis #(.COORD_BITS(COORD_BITS)) u_axis_y (
    .clk      (clk),
    .cmd      (cmd),
    .tension  (tension),
    .u        (u),
    .held     (held),
    .coord_in (in_y),
    .emit_val (y_val)
  );

  assign u_sum = {1'b0, u} + {1'b0, u_step};

  always_comb begin
    stat.first    = item_first;
    stat.last     = item_last;
    stat.full     = (held == HELD_FULL);
    stat.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= '0;
      out_valid  <= 1'b0;
      item_first <= 1'b0;
      item_last  <= 1'b0;
    end else begin
      if (cmd.first_load) begin
        held <= HELD_START;
      end else if (cmd.store) begin
        held <= held + 2'd1;
      end else if (cmd.clear) begin
        held <= '0;
      end
      if (cmd.take) begin
        item_first <= first_point;
        item_last  <= last_point;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // u_j = j * u_step, saturating
  always_ff @(posedge clk) begin
    if (cmd.coef) begin
      u <= '0;
    end else if (cmd.load) begin
      u <= u_sum[cst_pkg::USTEP_W] ? '1 : u_sum[cst_pkg::USTEP_W-1:0];
    end
    if (cmd.emit) begin
      out_x        <= x_val;
      out_y        <= y_val;
      is_knot      <= (cmd.emit_sel != cst_pkg::EMIT_POINT);
      last_of_run  <= cmd.mark_last;
      end_of_curve <= cmd.mark_end;
    end
  end

`ifndef NO_ASSERTIONS
  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && end_of_curve |-> last_of_run)
    else $error("end of curve beat without last_of_run");
  a_store_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.store |-> !stat.full)
    else $error("knot stored into a full window");
`endif

endmodule

`default_nettype wire

/* src/cst_ctrl.sv */
`default_nettype none

module cst_ctrl #(
  parameter int MAX_GRAIN = 15
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [cst_pkg::GRAIN_W-1:0] grain,
  input  wire cst_pkg::stat_t              stat,
  output cst_pkg::cmd_t                    cmd
);

  localparam int JW = $clog2(MAX_GRAIN + 1);
  localparam int GW = (JW > cst_pkg::GRAIN_W) ? JW : cst_pkg::GRAIN_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_BEGIN = 4'd1;
  localparam logic [3:0] S_START = 4'd2;
  localparam logic [3:0] S_PUSH  = 4'd3;
  localparam logic [3:0] S_LOAD  = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_POINT = 4'd6;
  localparam logic [3:0] S_KNOT  = 4'd7;
  localparam logic [3:0] S_END   = 4'd8;

  localparam logic [2:0] PHASE_LAST = 3'd5;

  logic [3:0]    state, state_next;
  logic          pass, pass_next;
  logic          twice, twice_next;
  logic [2:0]    phase, phase_next;
  logic [JW-1:0] j, j_next, j_inc, g_eff;
  logic [GW-1:0] grain_e;

  assign grain_e = GW'(grain);
  assign g_eff   = (grain_e > GW'(MAX_GRAIN)) ? JW'(MAX_GRAIN) : JW'(grain_e);
  assign j_inc   = j + JW'(1);

  always_comb begin
    state_next = state;
    pass_next  = pass;
    twice_next = twice;
    phase_next = phase;
    j_next     = j;
    cmd        = '0;
    in_ready   = 1'b0;
    cmd.mul_stage = phase[2:1];
    cmd.mul_hi    = phase[0];
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take   = 1'b1;
          pass_next  = 1'b0;
          state_next = S_BEGIN;
        end
      end
      S_BEGIN: begin
        if (stat.first) begin
          cmd.first_load = 1'b1;
          twice_next     = 1'b0;
          state_next     = S_START;
        end else begin
          state_next = S_PUSH;
        end
      end
      S_START: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = cst_pkg::EMIT_ITEM;
          cmd.mark_last = twice && !stat.last;
          twice_next    = 1'b1;
          if (twice) begin
            if (stat.last) begin
              pass_next  = 1'b1;
              state_next = S_PUSH;
            end else begin
              state_next = S_IDLE;
            end
          end
        end
      end
      S_PUSH: begin
        if (stat.full) begin
          cmd.coef   = 1'b1;
          j_next     = '0;
          state_next = (g_eff == '0) ? S_KNOT : S_LOAD;
        end else begin
          cmd.store = 1'b1;
          priority if (!pass && stat.last) begin
            pass_next  = 1'b1;
            state_next = S_PUSH;
          end else if (pass) begin
            state_next = S_END;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        phase_next = '0;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        if (phase == PHASE_LAST) begin
          state_next = S_POINT;
        end else begin
          phase_next = phase + 3'd1;
        end
      end
      S_POINT: begin
        if (stat.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = cst_pkg::EMIT_POINT;
          j_next       = j_inc;
          state_next   = (j_inc == g_eff) ? S_KNOT : S_LOAD;
        end
      end
      S_KNOT: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = cst_pkg::EMIT_WINDOW;
          cmd.mark_last = !stat.last;
          cmd.shift     = 1'b1;
          priority if (!pass && stat.last) begin
            pass_next  = 1'b1;
            state_next = S_PUSH;
          end else if (pass) begin
            state_next = S_END;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_END: begin
        if (stat.out_free) begin
          cmd.emit      = 1'b1;
          cmd.emit_sel  = cst_pkg::EMIT_ITEM;
          cmd.mark_last = 1'b1;
          cmd.mark_end  = 1'b1;
          cmd.clear     = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pass  <= 1'b0;
      twice <= 1'b0;
      phase <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      twice <= twice_next;
      phase <= phase_next;
      j     <= j_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> stat.out_free)
    else $error("result written while output register is occupied");
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken before the first was processed");
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> phase <= PHASE_LAST)
    else $error("multiplier phase out of range");
`endif

endmodule

`default_nettype wire

/* test/cst_curve_checker.sv */
`default_nettype none

// scoreboard for the spline tessellator: tracks config writes, predicts curve
// points for every accepted control point and compares delivered beats in order
module cst_curve_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  cst_in_if                                    points,
  cst_out_if                                   curve,
  input  wire logic                            cfg_wr_en,
  input  wire logic [cst_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [cst_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                                   fail_count,
  output int                                   pending
);
  import cst_pkg::*;

  localparam int MAX_GRAIN   = 15;
  localparam int REPORT_MAX  = 10;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               knot;
    logic               run_end;
    logic               curve_end;
  } curve_pt_t;

  logic [TENSION_W-1:0] tension_r;
  logic [GRAIN_W-1:0]   grain_r;
  logic [USTEP_W-1:0]   u_step_r;
  logic signed [15:0]   win_x [3];
  logic signed [15:0]   win_y [3];
  int                   knots_held;
  curve_pt_t            pts_due [$];
  int                   fails = 0;

  // one axis of the cardinal cubic, exact, scaled by 2^56 then rounded half up
  function automatic logic signed [15:0] cubic_axis(
    input logic signed [15:0] ks, k1, k2, ke,
    input logic [15:0]        u
  );
    logic signed [127:0] t, uw, c0, c1, c2, c3, acc;
    t   = tension_r;
    uw  = u;
    c0  = -t * ks + (512 - t) * k1 + (t - 512) * k2 + t * ke;
    c1  = 2 * t * ks + (t - 768) * k1 + (768 - 2 * t) * k2 - t * ke;
    c2  = t * k2 - t * ks;
    c3  = 256 * k1;
    acc = c0;
    acc = acc * uw + (c1 <<< 16);
    acc = acc * uw + (c2 <<< 32);
    acc = acc * uw + (c3 <<< 48);
    acc = (acc + (128'sd1 <<< 55)) >>> 56;
    if (acc > 32767) return 16'sh7fff;
    if (acc < -32768) return 16'sh8000;
    return acc[15:0];
  endfunction

  task automatic add_point(input logic signed [15:0] x, y, input logic knot);
    curve_pt_t p;
    p.x         = x;
    p.y         = y;
    p.knot      = knot;
    p.run_end   = 1'b0;
    p.curve_end = 1'b0;
    pts_due.push_back(p);
  endtask

  task automatic mark_tail(input logic curve_end);
    curve_pt_t p;
    p = pts_due.pop_back();
    if (curve_end) p.curve_end = 1'b1;
    else p.run_end = 1'b1;
    pts_due.push_back(p);
  endtask

  task automatic push_knot(input logic signed [15:0] x, y);
    int unsigned g, j, uj;
    g = (grain_r > MAX_GRAIN) ? MAX_GRAIN : grain_r;
    if (knots_held < 3) begin
      win_x[knots_held] = x;
      win_y[knots_held] = y;
      knots_held++;
    end else begin
      for (j = 1; j <= g; j++) begin
        uj = j * u_step_r;
        if (uj > 65535) uj = 65535;
        add_point(cubic_axis(win_x[0], win_x[1], win_x[2], x, uj[15:0]),
                  cubic_axis(win_y[0], win_y[1], win_y[2], y, uj[15:0]), 1'b0);
      end
      add_point(win_x[2], win_y[2], 1'b1);
      win_x[0] = win_x[1]; win_x[1] = win_x[2]; win_x[2] = x;
      win_y[0] = win_y[1]; win_y[1] = win_y[2]; win_y[2] = y;
    end
  endtask

  task automatic predict_item(input logic signed [15:0] x, y, input logic first, last);
    int queued;
    queued = pts_due.size();
    if (first) begin
      win_x[0] = x; win_x[1] = x; win_x[2] = '0;
      win_y[0] = y; win_y[1] = y; win_y[2] = '0;
      knots_held = 2;
      add_point(x, y, 1'b1);
      add_point(x, y, 1'b1);
    end else begin
      push_knot(x, y);
    end
    if (last) begin
      push_knot(x, y);
      add_point(x, y, 1'b1);
      mark_tail(1'b1);
      knots_held = 0;
    end
    if (pts_due.size() > queued) mark_tail(1'b0);
  endtask

  task automatic check_point(input curve_pt_t got);
    curve_pt_t want;
    if (pts_due.size() == 0) begin
      fails++;
      if (fails <= REPORT_MAX)
        $display("unexpected curve beat: x=%0d y=%0d knot=%0b run_end=%0b curve_end=%0b",
                 got.x, got.y, got.knot, got.run_end, got.curve_end);
    end else begin
      want = pts_due.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.knot !== want.knot ||
          got.run_end !== want.run_end || got.curve_end !== want.curve_end) begin
        fails++;
        if (fails <= REPORT_MAX)
          $display("curve beat mismatch: want x=%0d y=%0d knot=%0b run_end=%0b curve_end=%0b%s",
                   want.x, want.y, want.knot, want.run_end, want.curve_end, "");
        if (fails <= REPORT_MAX)
          $display("                       got x=%0d y=%0d knot=%0b run_end=%0b curve_end=%0b",
                   got.x, got.y, got.knot, got.run_end, got.curve_end);
      end
    end
  endtask

  always @(posedge clk) begin
    curve_pt_t got;
    if (rst) begin
      tension_r  = TENSION_RESET;
      grain_r    = GRAIN_RESET;
      u_step_r   = USTEP_RESET;
      win_x      = '{default: '0};
      win_y      = '{default: '0};
      knots_held = 0;
      pts_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_TENSION: tension_r = cfg_wdata[TENSION_W-1:0];
          CFG_GRAIN:   grain_r   = cfg_wdata[GRAIN_W-1:0];
          CFG_U_STEP:  u_step_r  = cfg_wdata[USTEP_W-1:0];
          default: ;
        endcase
      end
      if (curve.valid && curve.ready) begin
        got.x         = curve.out_x;
        got.y         = curve.out_y;
        got.knot      = curve.is_knot;
        got.run_end   = curve.last_of_run;
        got.curve_end = curve.end_of_curve;
        check_point(got);
      end
      if (points.valid && points.ready)
        predict_item(points.in_x, points.in_y, points.first_point, points.last_point);
    end
    pending    <= pts_due.size();
    fail_count <= fails;
  end

endmodule

`default_nettype wire

/* test/tb_cardinal_spline_tessellator_core.sv */
`default_nettype none

module tb_cardinal_spline_tessellator_core;
  import cst_pkg::*;

  // cycles with no beat on either channel before the run is declared hung;
  // a grain-15 last point with a slow receiver stays well below this
  localparam int WATCHDOG_LIMIT = 4000;
  // a point that only fills the window gives no beat but keeps the block busy
  localparam int SETTLE_CYCLES  = 16;
  localparam int TAIL_CYCLES    = 50;
  localparam int PHASE_ITEMS    = 70;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  int send_idle_pct;
  int stall_pct;
  int idle_cycles = 0;
  int items_sent  = 0;
  int fail_count;
  int pending;
  int phase;
  int g;

  cst_in_if  #(.COORD_BITS(16)) points_if ();
  cst_out_if #(.COORD_BITS(16)) curve_if ();

  cardinal_spline_tessellator_core #(
    .COORD_BITS (16),
    .MAX_GRAIN  (15)
  ) uut (
    .clk       (clk),
    .rst       (rst),
    .points    (points_if),
    .curve     (curve_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // scoreboard sits beside the block and only watches
  cst_curve_checker curve_check (
    .clk        (clk),
    .rst        (rst),
    .points     (points_if),
    .curve      (curve_if),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #5 clk = ~clk;

  // receiver side: ready drops at random, rate set per phase
  always @(posedge clk) begin
    curve_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog on beats of either channel
  always @(posedge clk) begin
    if ((points_if.valid && points_if.ready) || (curve_if.valid && curve_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // full-range values half the time, with the rails and small numbers mixed in
  function automatic logic signed [15:0] rand_coord();
    case ($urandom_range(9))
      0:       return 16'sh7fff;
      1:       return 16'sh8000;
      2, 3, 4: return 16'($signed($urandom_range(600)) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  // one control point beat; sender gaps are inserted before the beat
  task automatic send_point(input logic signed [15:0] x, y, input logic first, last);
    while ($urandom_range(99) < send_idle_pct) begin
      points_if.valid <= 1'b0;
      @(posedge clk);
    end
    points_if.valid       <= 1'b1;
    points_if.in_x        <= x;
    points_if.in_y        <= y;
    points_if.first_point <= first;
    points_if.last_point  <= last;
    @(posedge clk);
    while (!points_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // all three registers, back to back, only while the block is idle
  task automatic write_config(input logic [TENSION_W-1:0] tension,
                              input logic [GRAIN_W-1:0] grain,
                              input logic [USTEP_W-1:0] u_step);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_TENSION;
    cfg_wdata <= CFG_DATA_W'(tension);
    @(posedge clk);
    cfg_index <= CFG_GRAIN;
    cfg_wdata <= CFG_DATA_W'(grain);
    @(posedge clk);
    cfg_index <= CFG_U_STEP;
    cfg_wdata <= CFG_DATA_W'(u_step);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // wait for every predicted beat, then let a silent window fill finish
  task automatic drain_and_settle();
    points_if.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly proper curves with random content; a few orphan points, stray
  // ends and curves that never get their last point
  task automatic random_phase(input int count);
    int start, len, k;
    start = items_sent;
    while (items_sent - start < count) begin
      case ($urandom_range(19))
        0: send_point(rand_coord(), rand_coord(), 1'b0, 1'b0);
        1: send_point(rand_coord(), rand_coord(), 1'b0, 1'b1);
        2: begin
          len = $urandom_range(1, 4);
          for (k = 0; k < len; k++)
            send_point(rand_coord(), rand_coord(), k == 0, 1'b0);
        end
        default: begin
          len = $urandom_range(1, 8);
          for (k = 0; k < len; k++)
            send_point(rand_coord(), rand_coord(), k == 0, k == len - 1);
        end
      endcase
    end
  endtask

  initial begin
    points_if.valid       = 1'b0;
    points_if.in_x        = '0;
    points_if.in_y        = '0;
    points_if.first_point = 1'b0;
    points_if.last_point  = 1'b0;
    curve_if.ready        = 1'b0;
    cfg_wr_en             = 1'b0;
    cfg_index             = CFG_TENSION;
    cfg_wdata             = '0;
    send_idle_pct         = 0;
    stall_pct             = 0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed, reset config (catmull-rom, grain 4)
    // points before any curve start only fill the window, the fourth emits
    send_point(16'sd100, -16'sd100, 1'b0, 1'b0);
    send_point(-16'sd200, 16'sd300, 1'b0, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b0, 1'b0);
    // curve end with no start seen
    send_point(16'sd5, 16'sd5, 1'b0, 1'b1);
    // single point curve: start and end on the same beat
    send_point(16'sh8000, 16'sh7fff, 1'b1, 1'b1);
    // rail to rail swings drive the interpolation into saturation
    send_point(16'sh8000, 16'sh8000, 1'b1, 1'b0);
    send_point(16'sh7fff, 16'sh7fff, 1'b0, 1'b0);
    send_point(16'sh8000, 16'sh7fff, 1'b0, 1'b0);
    send_point(16'sh7fff, 16'sh8000, 1'b0, 1'b0);
    send_point(16'sd0, -16'sd1, 1'b0, 1'b1);
    // small ordinary curve
    send_point(16'sd0, 16'sd0, 1'b1, 1'b0);
    send_point(16'sd10, 16'sd20, 1'b0, 1'b0);
    send_point(-16'sd7, 16'sd3, 1'b0, 1'b0);
    send_point(16'sd1, 16'sd1, 1'b0, 1'b1);
    // curve restarted before its end
    send_point(16'sd40, -16'sd40, 1'b1, 1'b0);
    send_point(16'sd80, 16'sd10, 1'b0, 1'b0);
    send_point(-16'sd5, 16'sd6, 1'b1, 1'b0);
    send_point(16'sd9, 16'sd9, 1'b0, 1'b1);
    drain_and_settle();

    // random phases, each with its own idling mix and register setting
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct <= 0;
          stall_pct     <= 0;
          write_config(9'd256, 4'd15, 16'd4096);
        end
        1: begin
          // grain 0: knots only
          send_idle_pct <= 55;
          stall_pct     <= 0;
          write_config(9'd0, 4'd0, 16'd0);
        end
        2: begin
          // tension above unity, u saturating from the second point on
          send_idle_pct <= 0;
          stall_pct     <= 55;
          write_config(9'd300, 4'd7, 16'hffff);
        end
        default: begin
          send_idle_pct <= 16;
          stall_pct     <= 16;
          g = $urandom_range(1, 15);
          write_config(9'($urandom_range(256)), 4'(g), 16'(65536 / (g + 1)));
        end
      endcase
      random_phase(PHASE_ITEMS);
      drain_and_settle();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
src/cst_pkg.sv
src/cst_in_if.sv
src/cst_out_if.sv
src/cst_axis.sv
src/cst_datapath.sv
src/cst_ctrl.sv
src/cardinal_spline_tessellator_core.sv
test/cst_curve_checker.sv
test/tb_cardinal_spline_tessellator_core.sv
